[sv/nlt_pkg.sv]
`timescale 1ns / 1ps

package nlt_pkg;

	localparam int NODES_DEF = 16;

	localparam int MASK_W    = 16;
	localparam int ROWS_W    = 8;
	localparam int TIMEOUT_W = 16;
	localparam int ID_W      = 8;
	localparam int RPM_W     = 16;
	localparam int CLK_W     = 32;
	localparam int REG_IDX_W = 2;

	localparam int COUNT_OUT_W = 5;
	localparam int TOTAL_OUT_W = 20;
	localparam int AVG_OUT_W   = 24;
	localparam int FRAC_W      = 8;

	localparam logic [REG_IDX_W-1:0] REG_ENABLE_MASK = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ROWS        = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_TIMEOUT     = 2'd2;

	localparam logic [MASK_W-1:0]    MASK_RST    = 16'hFFFF;
	localparam logic [ROWS_W-1:0]    ROWS_RST    = 8'd16;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd1000;

	localparam logic ACT_TICK   = 1'b0;
	localparam logic ACT_STATUS = 1'b1;

	typedef struct packed {
		logic [MASK_W-1:0]    section_enable_mask;
		logic [ROWS_W-1:0]    rows_used;
		logic [TIMEOUT_W-1:0] timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic             tick;
		logic             status;
		logic [ID_W-1:0]  node_id;
		logic [RPM_W-1:0] rpm;
		logic [CLK_W-1:0] clock_ms;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_LOAD,
		ST_DIV
	} state_t;

endpackage

[sv/node_liveness_table_with_rpm_stats_top.sv]
`timescale 1ns / 1ps

// Liveness table for NODES bus nodes with rpm statistics.
// Input channel (in_valid/in_stall): one beat is either a millisecond tick
// (action 0) or a status frame (action 1) carrying node_id and rpm_reading.
// A tick advances the millisecond clock and drops nodes whose age exceeds
// timeout_ms; a status frame for node 1..NODES marks it online and stores
// its rpm. Every input beat yields exactly one output beat on out_valid/
// out_stall with the count, any-online flag, total rpm and mean rpm x256
// over enabled, online nodes within the rows in use.
// The table updates at the accepting edge; the aggregate then travels down
// the row of cells, one cell per cycle, and a bit-serial divider forms the
// mean. No new beat is accepted while one is in flight; the next beat can
// be taken in the cycle after the result is loaded. A finished result
// waits in the output register while the receiver stalls; the next beat is
// accepted meanwhile but its result is held back until the register is
// free. Reset clears the clock, all online flags and the output valid, and
// loads the register defaults. Registers are to be written by the user
// through wr_en/wr_index/wr_data only while no beat is in flight; the
// block itself does not enforce this.
module node_liveness_table_with_rpm_stats_top #(
	parameter int NODES = nlt_pkg::NODES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [nlt_pkg::REG_IDX_W-1:0]        wr_index,
	input  logic [nlt_pkg::MASK_W-1:0]           wr_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 action,
	input  logic [nlt_pkg::ID_W-1:0]             node_id,
	input  logic [nlt_pkg::RPM_W-1:0]            rpm_reading,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [nlt_pkg::COUNT_OUT_W-1:0]      online_count,
	output logic                                 any_online,
	output logic [nlt_pkg::TOTAL_OUT_W-1:0]      total_rpm,
	output logic [nlt_pkg::AVG_OUT_W-1:0]        average_rpm_x256
);

	localparam int CNT_W  = $clog2(NODES + 1);
	localparam int SUM_W  = nlt_pkg::RPM_W + CNT_W;
	localparam int DVD_W  = SUM_W + nlt_pkg::FRAC_W;
	localparam int SWP_W  = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int CNT_XW = (CNT_W > nlt_pkg::COUNT_OUT_W) ? CNT_W : nlt_pkg::COUNT_OUT_W;
	localparam int SUM_XW = (SUM_W > nlt_pkg::TOTAL_OUT_W) ? SUM_W : nlt_pkg::TOTAL_OUT_W;

	nlt_pkg::cfg_t                cfg_q;
	nlt_pkg::state_t              state_q;
	nlt_pkg::state_t              state_nxt;
	nlt_pkg::cell_cmd_t           cmd;
	logic [nlt_pkg::CLK_W-1:0]    clock_q;
	logic [SWP_W-1:0]             sweep_cnt_q;
	logic                         in_accept;
	logic                         div_start;
	logic                         out_load;
	logic                         div_busy;
	logic [DVD_W-1:0]             quotient;
	logic [CNT_W-1:0]             acc_cnt [NODES+1];
	logic [SUM_W-1:0]             acc_sum [NODES+1];
	logic [CNT_W-1:0]             cnt_fin;
	logic [SUM_W-1:0]             sum_fin;
	logic [CNT_XW-1:0]            cnt_ext;
	logic [SUM_XW-1:0]            sum_ext;
	logic                         out_valid_q;
	logic [nlt_pkg::COUNT_OUT_W-1:0] count_q;
	logic                         any_q;
	logic [nlt_pkg::TOTAL_OUT_W-1:0] total_q;
	logic [nlt_pkg::AVG_OUT_W-1:0]   avg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.section_enable_mask <= nlt_pkg::MASK_RST;
			cfg_q.rows_used           <= nlt_pkg::ROWS_RST;
			cfg_q.timeout_ms          <= nlt_pkg::TIMEOUT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				nlt_pkg::REG_ENABLE_MASK: cfg_q.section_enable_mask <= wr_data;
				nlt_pkg::REG_ROWS:        cfg_q.rows_used <= wr_data[nlt_pkg::ROWS_W-1:0];
				nlt_pkg::REG_TIMEOUT:     cfg_q.timeout_ms <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign in_accept = in_valid && !in_stall;

	always_comb begin
		cmd.tick     = in_accept && (action == nlt_pkg::ACT_TICK);
		cmd.status   = in_accept && (action == nlt_pkg::ACT_STATUS);
		cmd.node_id  = node_id;
		cmd.rpm      = rpm_reading;
		cmd.clock_ms = (action == nlt_pkg::ACT_TICK) ? clock_q + 1'b1 : clock_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= '0;
		end else if (cmd.tick) begin
			clock_q <= cmd.clock_ms;
		end
	end

	assign acc_cnt[0] = '0;
	assign acc_sum[0] = '0;

	for (genvar i = 0; i < NODES; i++) begin : g_cell
		nlt_cell #(
			.IDX   (i + 1),
			.CNT_W (CNT_W),
			.SUM_W (SUM_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.cfg        (cfg_q),
			.acc_cnt_in (acc_cnt[i]),
			.acc_sum_in (acc_sum[i]),
			.acc_cnt    (acc_cnt[i+1]),
			.acc_sum    (acc_sum[i+1])
		);
	end

	assign cnt_fin = acc_cnt[NODES];
	assign sum_fin = acc_sum[NODES];

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			nlt_pkg::ST_IDLE:  if (in_accept) state_nxt = nlt_pkg::ST_SWEEP;
			nlt_pkg::ST_SWEEP: if (sweep_cnt_q == SWP_W'(NODES - 1)) state_nxt = nlt_pkg::ST_LOAD;
			nlt_pkg::ST_LOAD:  state_nxt = nlt_pkg::ST_DIV;
			nlt_pkg::ST_DIV:   if (out_load) state_nxt = nlt_pkg::ST_IDLE;
			default:           state_nxt = nlt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != nlt_pkg::ST_IDLE);
		div_start = (state_q == nlt_pkg::ST_LOAD);
		out_load  = (state_q == nlt_pkg::ST_DIV) && !div_busy && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nlt_pkg::ST_IDLE;
			sweep_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (in_accept) begin
				sweep_cnt_q <= '0;
			end else if (state_q == nlt_pkg::ST_SWEEP) begin
				sweep_cnt_q <= sweep_cnt_q + 1'b1;
			end
		end
	end

	nlt_div #(
		.DVD_W (DVD_W),
		.DVS_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({sum_fin, nlt_pkg::FRAC_W'(0)}),
		.divisor  (cnt_fin),
		.busy     (div_busy),
		.quotient (quotient)
	);

	assign cnt_ext = CNT_XW'(cnt_fin);
	assign sum_ext = SUM_XW'(sum_fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			count_q <= (cnt_ext > CNT_XW'(31)) ? nlt_pkg::COUNT_OUT_W'(31)
				: cnt_ext[nlt_pkg::COUNT_OUT_W-1:0];
			any_q   <= (cnt_fin != '0);
			total_q <= (sum_ext > SUM_XW'(20'hFFFFF)) ? nlt_pkg::TOTAL_OUT_W'(20'hFFFFF)
				: sum_ext[nlt_pkg::TOTAL_OUT_W-1:0];
			avg_q   <= (cnt_fin == '0) ? '0 : quotient[nlt_pkg::AVG_OUT_W-1:0];
		end
	end

	assign out_valid        = out_valid_q;
	assign online_count     = count_q;
	assign any_online       = any_q;
	assign total_rpm        = total_q;
	assign average_rpm_x256 = avg_q;

	a_flag_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (any_online == (online_count != '0)))
		else $error("any_online disagrees with online_count");

	a_zero_count_zero_avg: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && online_count == '0) |-> (average_rpm_x256 == '0))
		else $error("non-zero average with no nodes counted");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q == nlt_pkg::ST_SWEEP && sweep_cnt_q == '0))
		else $error("accepted beat did not start the sweep");

	a_load_needs_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!div_busy && !div_start))
		else $error("result loaded while the divider was running");

endmodule

[sv/nlt_cell.sv]
`timescale 1ns / 1ps

module nlt_cell #(
	parameter int IDX   = 1,
	parameter int CNT_W = 5,
	parameter int SUM_W = 21
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nlt_pkg::cell_cmd_t   cmd,
	input  nlt_pkg::cfg_t        cfg,
	input  logic [CNT_W-1:0]     acc_cnt_in,
	input  logic [SUM_W-1:0]     acc_sum_in,
	output logic [CNT_W-1:0]     acc_cnt,
	output logic [SUM_W-1:0]     acc_sum
);

	logic                          online_q;
	logic [nlt_pkg::CLK_W-1:0]     last_seen_q;
	logic [nlt_pkg::RPM_W-1:0]     rpm_q;
	logic [CNT_W-1:0]              acc_cnt_q;
	logic [SUM_W-1:0]              acc_sum_q;
	logic                          enabled;
	logic                          counted;
	logic                          id_hit;
	logic                          expired;
	logic [nlt_pkg::CLK_W-1:0]     age;

	if (IDX <= nlt_pkg::MASK_W) begin : g_en
		assign enabled = cfg.section_enable_mask[IDX-1];
	end else begin : g_no_en
		assign enabled = 1'b0;
	end

	assign id_hit  = (cmd.node_id == nlt_pkg::ID_W'(IDX));
	assign age     = cmd.clock_ms - last_seen_q;
	assign expired = age > nlt_pkg::CLK_W'(cfg.timeout_ms);
	assign counted = enabled && online_q && (cfg.rows_used >= nlt_pkg::ROWS_W'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			online_q    <= 1'b0;
			last_seen_q <= '0;
			rpm_q       <= '0;
		end else if (cmd.status && id_hit) begin
			online_q    <= 1'b1;
			last_seen_q <= cmd.clock_ms;
			rpm_q       <= cmd.rpm;
		end else if (cmd.tick && online_q && expired) begin
			online_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		acc_cnt_q <= acc_cnt_in + CNT_W'(counted);
		acc_sum_q <= acc_sum_in + (counted ? SUM_W'(rpm_q) : '0);
	end

	assign acc_cnt = acc_cnt_q;
	assign acc_sum = acc_sum_q;

endmodule

[sv/nlt_div.sv]
`timescale 1ns / 1ps

module nlt_div #(
	parameter int DVD_W = 29,
	parameter int DVS_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic [DVD_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W:0]    shifted;
	logic [DVS_W+1:0]  diff;
	logic              fits;

	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign fits    = !diff[DVS_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(DVD_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

[tb/sv/node_liveness_table_with_rpm_stats_top_tb.sv]
`timescale 1ns / 1ps

module node_liveness_table_with_rpm_stats_top_tb;

	localparam int NODES = nlt_pkg::NODES_DEF;
	localparam int LATENCY = NODES + 24 + $clog2(NODES + 1) + 3;
	localparam int QUIET_LIMIT = 3000;
	localparam int PHASES = 9;
	localparam int BEATS_PER_PHASE = 142;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [nlt_pkg::COUNT_OUT_W-1:0] n_online;
		logic                            any_on;
		logic [nlt_pkg::TOTAL_OUT_W-1:0] rpm_sum;
		logic [nlt_pkg::AVG_OUT_W-1:0]   rpm_mean_x256;
	} stats_t;

	class node_table_tracker;
		logic [nlt_pkg::MASK_W-1:0]    enable_mask;
		logic [nlt_pkg::ROWS_W-1:0]    row_limit;
		logic [nlt_pkg::TIMEOUT_W-1:0] timeout;
		logic [nlt_pkg::CLK_W-1:0]     now_ms;
		bit                            online[NODES];
		logic [nlt_pkg::CLK_W-1:0]     last_seen[NODES];
		logic [nlt_pkg::RPM_W-1:0]     rpm[NODES];
		stats_t                        expected_stats[$];
		int                            errors;

		function new();
			enable_mask = nlt_pkg::MASK_RST;
			row_limit = nlt_pkg::ROWS_RST;
			timeout = nlt_pkg::TIMEOUT_RST;
			now_ms = '0;
			errors = 0;
			for (int i = 0; i < NODES; i++) begin
				online[i] = 1'b0;
				last_seen[i] = '0;
				rpm[i] = '0;
			end
		endfunction

		function void set_reg(logic [nlt_pkg::REG_IDX_W-1:0] idx,
				logic [nlt_pkg::MASK_W-1:0] val);
			case (idx)
				nlt_pkg::REG_ENABLE_MASK: enable_mask = val;
				nlt_pkg::REG_ROWS:        row_limit = val[nlt_pkg::ROWS_W-1:0];
				nlt_pkg::REG_TIMEOUT:     timeout = val[nlt_pkg::TIMEOUT_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_beat(logic act, logic [nlt_pkg::ID_W-1:0] id,
				logic [nlt_pkg::RPM_W-1:0] rpm_in);
			logic [nlt_pkg::CLK_W-1:0] age;
			int limit;
			int count;
			logic [31:0] total;
			logic [39:0] mean;
			stats_t want;
			if (act == nlt_pkg::ACT_TICK) begin
				now_ms = now_ms + 1;
				for (int i = 0; i < NODES; i++) begin
					age = now_ms - last_seen[i];
					if (online[i] && age > nlt_pkg::CLK_W'(timeout))
						online[i] = 1'b0;
				end
			end else if (id >= 1 && id <= NODES) begin
				online[id - 1] = 1'b1;
				last_seen[id - 1] = now_ms;
				rpm[id - 1] = rpm_in;
			end
			limit = (row_limit < NODES) ? int'(row_limit) : NODES;
			count = 0;
			total = '0;
			for (int n = 1; n <= limit; n++) begin
				if (n <= nlt_pkg::MASK_W && enable_mask[n - 1] && online[n - 1]) begin
					count++;
					total = total + rpm[n - 1];
				end
			end
			mean = (count > 0) ? ({8'h00, total} << nlt_pkg::FRAC_W) / count : '0;
			want.n_online = (count > 31) ? 5'd31 : nlt_pkg::COUNT_OUT_W'(count);
			want.any_on = (count > 0);
			want.rpm_sum = (total > 32'hFFFFF) ? 20'hFFFFF : total[nlt_pkg::TOTAL_OUT_W-1:0];
			want.rpm_mean_x256 = mean[nlt_pkg::AVG_OUT_W-1:0];
			expected_stats.push_back(want);
		endfunction

		function void compare_stats(stats_t got);
			stats_t want;
			if (expected_stats.size() == 0) begin
				$display("%0t: unexpected result beat: count %0d any %0d total %0d mean %0d",
					$time, got.n_online, got.any_on, got.rpm_sum, got.rpm_mean_x256);
				errors++;
				return;
			end
			want = expected_stats.pop_front();
			if (got.n_online !== want.n_online) begin
				$display("%0t: online_count expected %0d actual %0d",
					$time, want.n_online, got.n_online);
				errors++;
			end
			if (got.any_on !== want.any_on) begin
				$display("%0t: any_online expected %0d actual %0d",
					$time, want.any_on, got.any_on);
				errors++;
			end
			if (got.rpm_sum !== want.rpm_sum) begin
				$display("%0t: total_rpm expected %0d actual %0d",
					$time, want.rpm_sum, got.rpm_sum);
				errors++;
			end
			if (got.rpm_mean_x256 !== want.rpm_mean_x256) begin
				$display("%0t: average_rpm_x256 expected %0d actual %0d",
					$time, want.rpm_mean_x256, got.rpm_mean_x256);
				errors++;
			end
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            wr_en;
	logic [nlt_pkg::REG_IDX_W-1:0]   wr_index;
	logic [nlt_pkg::MASK_W-1:0]      wr_data;
	logic                            in_valid;
	logic                            in_stall;
	logic                            action;
	logic [nlt_pkg::ID_W-1:0]        node_id;
	logic [nlt_pkg::RPM_W-1:0]       rpm_reading;
	logic                            out_valid;
	logic                            out_stall;
	logic [nlt_pkg::COUNT_OUT_W-1:0] online_count;
	logic                            any_online;
	logic [nlt_pkg::TOTAL_OUT_W-1:0] total_rpm;
	logic [nlt_pkg::AVG_OUT_W-1:0]   average_rpm_x256;

	node_table_tracker tracker = new();
	int send_idle_pct = 21;
	int recv_idle_pct = 73;
	int hold_request = 0;
	int quiet_cycles = 0;

	node_liveness_table_with_rpm_stats_top #(.NODES(NODES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.node_id(node_id),
		.rpm_reading(rpm_reading),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.online_count(online_count),
		.any_online(any_online),
		.total_rpm(total_rpm),
		.average_rpm_x256(average_rpm_x256)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A long hold-off, once requested, is counted down here so that the block fills up.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.compare_stats({online_count, any_online, total_rpm, average_rpm_x256});
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_beat(input logic act, input logic [nlt_pkg::ID_W-1:0] id,
			input logic [nlt_pkg::RPM_W-1:0] rpm_val);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		node_id <= id;
		rpm_reading <= rpm_val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.take_beat(act, id, rpm_val);
	endtask

	task automatic send_random_beat();
		int pick;
		logic [nlt_pkg::ID_W-1:0] id;
		logic [nlt_pkg::RPM_W-1:0] rpm_val;
		pick = $urandom_range(99);
		rpm_val = nlt_pkg::RPM_W'($urandom_range(65535));
		if ($urandom_range(9) == 0)
			rpm_val = $urandom_range(1) ? 16'hFFFF : 16'h0000;
		if (pick < 40) begin
			send_beat(nlt_pkg::ACT_TICK, nlt_pkg::ID_W'($urandom_range(255)), rpm_val);
		end else if (pick < 92) begin
			send_beat(nlt_pkg::ACT_STATUS, nlt_pkg::ID_W'($urandom_range(NODES, 1)), rpm_val);
		end else begin
			id = $urandom_range(1) ? 8'd0 : nlt_pkg::ID_W'($urandom_range(255, NODES + 1));
			send_beat(nlt_pkg::ACT_STATUS, id, rpm_val);
		end
	endtask

	task automatic drain_block();
		in_valid <= 1'b0;
		while (tracker.expected_stats.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(input logic [nlt_pkg::REG_IDX_W-1:0] idx,
			input logic [nlt_pkg::MASK_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		tracker.set_reg(idx, val);
	endtask

	task automatic set_config(input logic [nlt_pkg::MASK_W-1:0] mask,
			input logic [nlt_pkg::ROWS_W-1:0] rows,
			input logic [nlt_pkg::TIMEOUT_W-1:0] tmo);
		drain_block();
		write_reg(nlt_pkg::REG_ENABLE_MASK, mask);
		write_reg(nlt_pkg::REG_ROWS, nlt_pkg::MASK_W'(rows));
		write_reg(nlt_pkg::REG_TIMEOUT, tmo);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		logic [nlt_pkg::MASK_W-1:0] mask;
		logic [nlt_pkg::ROWS_W-1:0] rows;
		logic [nlt_pkg::TIMEOUT_W-1:0] tmo;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_valid = 1'b0;
		action = nlt_pkg::ACT_TICK;
		node_id = '0;
		rpm_reading = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A tick with junk fields, bad node ids, every node at full rpm, then a zero reading.
		send_beat(nlt_pkg::ACT_TICK, 8'hFF, 16'hFFFF);
		send_beat(nlt_pkg::ACT_STATUS, 8'd0, 16'd1234);
		send_beat(nlt_pkg::ACT_STATUS, 8'(NODES + 1), 16'd4321);
		send_beat(nlt_pkg::ACT_STATUS, 8'hFF, 16'hFFFF);
		for (int n = 1; n <= NODES; n++)
			send_beat(nlt_pkg::ACT_STATUS, nlt_pkg::ID_W'(n), 16'hFFFF);
		send_beat(nlt_pkg::ACT_STATUS, 8'd1, 16'h0000);
		send_beat(nlt_pkg::ACT_TICK, 8'h00, 16'h0000);
		// With a zero timeout the next tick takes every node offline.
		set_config(16'hFFFF, 8'd16, 16'd0);
		send_beat(nlt_pkg::ACT_STATUS, 8'd5, 16'd777);
		send_beat(nlt_pkg::ACT_TICK, 8'h5A, 16'hA5A5);

		for (int phase = 0; phase < PHASES; phase++) begin
			mask = nlt_pkg::MASK_W'($urandom_range(65535));
			rows = nlt_pkg::ROWS_W'($urandom_range(15, 1));
			tmo = nlt_pkg::TIMEOUT_W'($urandom_range(40));
			case (phase)
				0: set_config(16'hFFFF, 8'd16, 16'd5);
				1: set_config(16'h0000, 8'd16, 16'd20);
				2: set_config(mask, 8'd255, 16'd0);
				3: set_config(16'hFFFF, 8'd0, 16'd3);
				4: set_config(mask, rows, 16'd10);
				5: set_config(16'hFFFF, 8'd16, 16'hFFFF);
				6: set_config(mask, 8'd17, 16'd1);
				7: set_config(16'h8001, 8'd16, 16'd8);
				default: set_config(mask, nlt_pkg::ROWS_W'($urandom_range(20)), tmo);
			endcase
			if (phase < 3) begin
				send_idle_pct = 21;
				recv_idle_pct = 73;
			end else if (phase < 6) begin
				send_idle_pct = 73;
				recv_idle_pct = 21;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (phase == 4 || phase == 7)
				hold_request = HOLD_CYCLES;
			for (int k = 0; k < BEATS_PER_PHASE; k++)
				send_random_beat();
		end

		drain_block();
		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.expected_stats.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
sv/nlt_pkg.sv
sv/nlt_cell.sv
sv/nlt_div.sv
sv/node_liveness_table_with_rpm_stats_top.sv
tb/sv/node_liveness_table_with_rpm_stats_top_tb.sv
